### rtl/ssdm_pkg.sv
// package for the stokes sphere drag mobility core
// holds payload structs and the fixed point drag constants; no dependencies
package ssdm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned QW = 33;            // quotient bits kept per divide
  localparam int unsigned DtW = 97;           // 33 + 32 + 32
  localparam int unsigned DrW = 161;          // 33 + 4*32
  localparam int unsigned NtW = 92;           // 32-bit magnitude << 60
  localparam int unsigned NrW = 124;          // 32-bit magnitude << 92
  localparam logic [32:0] K6Pi = 33'd5059889139;
  localparam logic [32:0] K8Pi = 33'd6746518852;
  localparam int unsigned ViscReset = 65536;

  typedef struct packed {
    logic [31:0] radius;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic fault;
  } res_t;

endpackage

### rtl/stokes_sphere_drag_mobility_core.sv
// top level of the stokes sphere drag mobility core
// depends on ssdm_pkg
//
// Streaming sphere mobility: one request per cycle, busy is always low, and
// every request gives exactly one result strobe, after the ten-stage limb
// multiplier, an input register for the divider, the radix-2 restoring divider
// pipeline with one quotient bit per stage and an output register. The
// receiver cannot stall; results are shown for one cycle only. Write viscosity
// only while no request is in flight.
module stokes_sphere_drag_mobility_core
  import ssdm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  input  logic       cfg_we,
  input  logic [31:0] cfg_data,
  output logic       done,
  output res_t       res
);

  localparam int unsigned ProdStg = 10;

  logic [31:0] viscosity;
  always_ff @(posedge clk) begin
    if (rst) viscosity <= 32'(ViscReset);
    else if (cfg_we) viscosity <= cfg_data;
  end
  assign busy = 1'b0;

  // product pipeline: one 33x32 limb multiply-add per stage
  // stage 0 forms k*r for both drags; dt takes mu in stages 1-2;
  // dr takes r in stages 1-2 and 3-5, then mu in stages 6-9
  logic [ProdStg:0] pv;
  logic [DtW-1:0] dt [ProdStg+1];    // running product
  logic [DtW-1:0] dts [ProdStg+1];   // multiplicand of the current round
  logic [DrW-1:0] dr [ProdStg+1];
  logic [DrW-1:0] drs [ProdStg+1];
  logic [31:0] pr [ProdStg+1];
  logic [31:0] pmu [ProdStg+1];
  req_t pq [ProdStg+1];
  logic pz [ProdStg+1];

  assign pv[0] = start;
  assign pq[0] = req;
  assign pr[0] = req.radius;
  assign pmu[0] = viscosity;
  assign pz[0] = (req.radius == 32'd0) || (viscosity == 32'd0);
  assign dt[0] = DtW'(K6Pi);
  assign dr[0] = DrW'(K8Pi);
  assign dts[0] = '0;
  assign drs[0] = '0;

  function automatic logic [64:0] limb_mul(logic [32:0] a, logic [31:0] b);
    return a * b;
  endfunction

  for (genvar s = 0; s < ProdStg; s++) begin : g_prod
    // dr role: 0 first product, 1 round start (low limb), 2 add of a higher limb
    localparam int RKind = (s == 0) ? 0 : ((s == 1) || (s == 3) || (s == 6)) ? 1 : 2;
    localparam int RLimb = (s < 1) ? 0 : (s < 3) ? s - 1 : (s < 6) ? s - 3 : s - 6;
    localparam bit RTop = (s == 2) || (s == 5) || (s == 9);   // 33-bit top limb
    always_ff @(posedge clk) begin
      if (rst) pv[s+1] <= 1'b0;
      else pv[s+1] <= pv[s];
      pq[s+1] <= pq[s];
      pr[s+1] <= pr[s];
      pmu[s+1] <= pmu[s];
      pz[s+1] <= pz[s];
      if (s == 0) begin
        dts[s+1] <= dts[s];
        dt[s+1] <= DtW'(limb_mul(dt[s][32:0], pr[s]));
      end else if (s == 1) begin
        dts[s+1] <= dt[s];
        dt[s+1] <= DtW'(limb_mul({1'b0, dt[s][31:0]}, pmu[s]));
      end else if (s == 2) begin
        dts[s+1] <= dts[s];
        dt[s+1] <= dt[s] + (DtW'(limb_mul(dts[s][64:32], pmu[s])) << 32);
      end else begin
        dts[s+1] <= dts[s];
        dt[s+1] <= dt[s];
      end
      if (RKind == 0) begin
        drs[s+1] <= drs[s];
        dr[s+1] <= DrW'(limb_mul(dr[s][32:0], pr[s]));
      end else if (RKind == 1) begin
        drs[s+1] <= dr[s];
        dr[s+1] <= DrW'(limb_mul({1'b0, dr[s][31:0]}, (s < 6) ? pr[s] : pmu[s]));
      end else begin
        drs[s+1] <= drs[s];
        dr[s+1] <= dr[s] + (DrW'(limb_mul(RTop ? drs[s][32*RLimb +: 33]
                                               : {1'b0, drs[s][32*RLimb +: 32]},
                                          (s < 6) ? pr[s] : pmu[s])) << (32*RLimb));
      end
    end
  end

  // magnitudes of the six components
  logic [5:0][31:0] mag;
  logic [5:0] neg;
  logic signed [5:0][31:0] comp;
  assign comp = {pq[ProdStg].force_x, pq[ProdStg].force_y, pq[ProdStg].force_z,
                 pq[ProdStg].torque_x, pq[ProdStg].torque_y, pq[ProdStg].torque_z};
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      neg[i] = comp[i][31];
      mag[i] = neg[i] ? (32'd0 - comp[i]) : comp[i];
    end
  end

  // divider pipeline: quotient of (mag << sh) / d, bit by bit, msb first.
  // the quotient cannot exceed 2^33 usefully; higher bits imply saturation,
  // detected up front by comparing the numerator against d << QW
  // lanes 5..3 carry the force, lanes 2..0 the torque
  localparam int unsigned RemW = DrW + 1;
  logic dv [QW+1];
  logic [5:0][RemW-1:0] rem [QW+1];
  logic [5:0][QW-1:0] quo [QW+1];
  logic [5:0] big [QW+1];
  logic [5:0] sn [QW+1];
  logic dz [QW+1];
  logic [DtW-1:0] ddt [QW+1];
  logic [DrW-1:0] ddr [QW+1];

  always_ff @(posedge clk) begin
    logic [NrW+QW:0] num;
    logic [DrW+QW:0] dsh;
    if (rst) dv[0] <= 1'b0;
    else dv[0] <= pv[ProdStg];
    dz[0] <= pz[ProdStg];
    ddt[0] <= dt[ProdStg];
    ddr[0] <= dr[ProdStg];
    sn[0] <= neg;
    for (int i = 0; i < 6; i++) begin
      num = (i >= 3) ? ((NrW+QW+1)'(mag[i]) << 60) : ((NrW+QW+1)'(mag[i]) << 92);
      dsh = (i >= 3) ? ((DrW+QW+1)'(dt[ProdStg]) << QW)
                     : ((DrW+QW+1)'(dr[ProdStg]) << QW);
      big[0][i] <= (DrW+QW+1)'(num) >= dsh;
      rem[0][i] <= RemW'(num >> QW);
      quo[0][i] <= QW'(num);
    end
  end

  for (genvar b = 0; b < QW; b++) begin : g_div
    always_ff @(posedge clk) begin
      logic [RemW-1:0] r;
      logic [RemW-1:0] d;
      if (rst) dv[b+1] <= 1'b0;
      else dv[b+1] <= dv[b];
      dz[b+1] <= dz[b];
      ddt[b+1] <= ddt[b];
      ddr[b+1] <= ddr[b];
      sn[b+1] <= sn[b];
      big[b+1] <= big[b];
      for (int i = 0; i < 6; i++) begin
        r = {rem[b][i][RemW-2:0], quo[b][i][QW-1]};
        d = (i >= 3) ? RemW'(ddt[b]) : RemW'(ddr[b]);
        if (r >= d) begin
          rem[b+1][i] <= r - d;
          quo[b+1][i] <= {quo[b][i][QW-2:0], 1'b1};
        end else begin
          rem[b+1][i] <= r;
          quo[b+1][i] <= {quo[b][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // sign, saturation and zero-drag handling
  always_ff @(posedge clk) begin
    logic [5:0][31:0] o;
    logic f;
    f = dz[QW];
    for (int i = 0; i < 6; i++) begin
      if (dz[QW]) o[i] = 32'd0;
      else if (sn[QW][i]) begin
        if (big[QW][i] || quo[QW][i] > 33'h080000000) begin
          o[i] = 32'h80000000;
          f = 1'b1;
        end else o[i] = 32'(33'd0 - quo[QW][i]);
      end else begin
        if (big[QW][i] || quo[QW][i] > 33'h07fffffff) begin
          o[i] = 32'h7fffffff;
          f = 1'b1;
        end else o[i] = quo[QW][i][31:0];
      end
    end
    if (rst) done <= 1'b0;
    else done <= dv[QW];
    res <= {o[5], o[4], o[3], o[2], o[1], o[0], f};
  end

endmodule

### tb/testbench.sv
// self-checking testbench for stokes_sphere_drag_mobility_core
// depends on ssdm_pkg and the core; predicts each result with wide integer division
module testbench;
  import ssdm_pkg::*;

  localparam int unsigned MaxCycles = 300000;
  localparam int unsigned DrainCycles = 100;   // covers the divider pipeline depth

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic done;
  res_t res;

  // pending requests, the testbench copy of viscosity and the expected results
  req_t sphere_q[$];
  res_t mobility_q[$];
  logic [31:0] visc_copy = 32'(ViscReset);
  bit quiet = 1'b0;                  // no idle cycles while set
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned faults_seen = 0;
  int unsigned cycles = 0;

  stokes_sphere_drag_mobility_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .res(res)
  );

  always #5 clk = ~clk;

  // one quotient with pre-shift, truncated toward zero and saturated
  function automatic logic [31:0] drag_quot(logic signed [31:0] v, int unsigned sh,
                                            logic [255:0] den, ref bit fault);
    logic [255:0] num;
    logic [255:0] q;
    logic [32:0] mag;
    bit neg;
    neg = v[31];
    mag = neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    num = 256'(mag) << sh;
    q = num / den;
    if (neg) begin
      if (q > 256'h8000_0000) begin
        fault = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(33'h1_0000_0000 - q[32:0]);
    end
    if (q > 256'h7fff_ffff) begin
      fault = 1'b1;
      return 32'h7fff_ffff;
    end
    return q[31:0];
  endfunction

  // velocity = F / (6 pi mu r), spin = T / (8 pi mu r^3)
  function automatic res_t sphere_mobility(req_t s, logic [31:0] mu);
    res_t o;
    logic [255:0] trans_drag;
    logic [255:0] rot_drag;
    logic [255:0] r;
    bit fault;
    o = '0;
    fault = 1'b0;
    if (s.radius == 0 || mu == 0) begin
      o.fault = 1'b1;
      return o;
    end
    r = 256'(s.radius);
    trans_drag = 256'(K6Pi) * r * 256'(mu);
    rot_drag = 256'(K8Pi) * r * r * r * 256'(mu);
    o.vel_x = drag_quot(s.force_x, 60, trans_drag, fault);
    o.vel_y = drag_quot(s.force_y, 60, trans_drag, fault);
    o.vel_z = drag_quot(s.force_z, 60, trans_drag, fault);
    o.spin_x = drag_quot(s.torque_x, 92, rot_drag, fault);
    o.spin_y = drag_quot(s.torque_y, 92, rot_drag, fault);
    o.spin_z = drag_quot(s.torque_z, 92, rot_drag, fault);
    o.fault = fault;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // value of random magnitude, so both tiny and huge operands show up
  function automatic logic [31:0] rand_word();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] rand_signed();
    logic [31:0] v;
    v = rand_word();
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  function automatic req_t rand_sphere();
    req_t s;
    s.radius = ($urandom_range(0, 49) == 0) ? 32'd0 : rand_word();
    s.force_x = rand_signed();
    s.force_y = rand_signed();
    s.force_z = ($urandom_range(0, 9) == 0) ? $urandom() : rand_signed();
    s.torque_x = rand_signed();
    s.torque_y = rand_signed();
    s.torque_z = ($urandom_range(0, 9) == 0) ? $urandom() : rand_signed();
    return s;
  endfunction

  // driver: a request stays on the port until the core takes it
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mobility_q.push_back(sphere_mobility(req, visc_copy));
      end
      if (!start || !busy) begin
        if (sphere_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
          req <= sphere_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each strobe is checked against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (mobility_q.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        want = mobility_q.pop_front();
        checked++;
        if (want.fault) faults_seen++;
        if (res.vel_x !== want.vel_x) report_mismatch("vel_x", res.vel_x, want.vel_x);
        if (res.vel_y !== want.vel_y) report_mismatch("vel_y", res.vel_y, want.vel_y);
        if (res.vel_z !== want.vel_z) report_mismatch("vel_z", res.vel_z, want.vel_z);
        if (res.spin_x !== want.spin_x) report_mismatch("spin_x", res.spin_x, want.spin_x);
        if (res.spin_y !== want.spin_y) report_mismatch("spin_y", res.spin_y, want.spin_y);
        if (res.spin_z !== want.spin_z) report_mismatch("spin_z", res.spin_z, want.spin_z);
        if (res.fault !== want.fault) report_mismatch("fault", 32'(res.fault), 32'(want.fault));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // wait until every request is taken and every result is back, then let the pipe empty
  task automatic drain();
    while (sphere_q.size() > 0 || start || mobility_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_viscosity(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    visc_copy = v;
  endtask

  task automatic push_sphere(logic [31:0] r, logic [31:0] f, logic [31:0] t);
    req_t s;
    s.radius = r;
    s.force_x = f;
    s.force_y = -f;
    s.force_z = f ^ 32'h5555_5555;
    s.torque_x = t;
    s.torque_y = -t;
    s.torque_z = t ^ 32'haaaa_aaaa;
    sphere_q.push_back(s);
  endtask

  task automatic random_phase(int unsigned n);
    for (int unsigned i = 0; i < n; i++) sphere_q.push_back(rand_sphere());
  endtask

  initial begin
    logic [31:0] visc_set[8];
    visc_set = '{32'd1, 32'hffff_ffff, 32'd0, 32'd65536, 32'd16, 32'h0100_0000,
                 32'd0, 32'd0};
    visc_set[6] = rand_word() | 32'd1;
    visc_set[7] = $urandom();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reset viscosity, field extremes, zero drag, saturation both ways
    quiet = 1'b1;
    push_sphere(32'd65536, 32'd65536, 32'd65536);
    push_sphere(32'd0, 32'h7fff_ffff, 32'h8000_0000);
    push_sphere(32'd1, 32'h7fff_ffff, 32'h7fff_ffff);
    push_sphere(32'd1, 32'h8000_0000, 32'h8000_0000);
    push_sphere(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_sphere(32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff);
    push_sphere(32'd65536, 32'd0, 32'd0);
    push_sphere(32'd65536, 32'hffff_ffff, 32'd1);
    push_sphere(32'd256, 32'h0001_0000, 32'hffff_0000);
    push_sphere(32'h0010_0000, 32'h4000_0000, 32'hc000_0000);
    push_sphere(32'd3, 32'h0000_0100, 32'h8000_0001);
    push_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    random_phase(8);
    drain();
    quiet = 1'b0;
    random_phase(180);
    drain();

    // random items under a sweep of viscosity values, extremes included
    foreach (visc_set[k]) begin
      write_viscosity(visc_set[k]);
      quiet = (k == 3);              // one phase with no idling at all
      push_sphere(32'd65536, 32'h7fff_ffff, 32'h8000_0000);
      random_phase(165);
      drain();
    end

    $display("checked %0d results over %0d viscosity settings, %0d flagged",
             checked, 9, faults_seen);
    $display("covered zero drag, saturation of both signs and random operand sizes");
    if (errors == 0 && mobility_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/ssdm_pkg.sv
rtl/stokes_sphere_drag_mobility_core.sv
tb/testbench.sv
